### rtl/repd_pkg.sv
// Shared types, field layout and constants of the rumble envelope driver.
package repd_pkg;

  // Stream and configuration widths
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Item fields
  localparam int unsigned PORT_W  = 2;
  localparam int unsigned DUR_W   = 15;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned DIST_W  = 31;
  localparam int unsigned THR_W   = 8;

  // Bit positions inside the request tdata
  localparam int unsigned CTRL_LSB  = 0;
  localparam int unsigned DUR_LSB   = 2;
  localparam int unsigned START_LSB = 17;
  localparam int unsigned END_LSB   = 33;
  localparam int unsigned DIST_LSB  = 49;
  localparam int unsigned PAK_BIT   = 80;

  // Distance scaling
  localparam int unsigned DIST_SHIFT = 6;
  localparam int unsigned DSC_W      = DIST_W - DIST_SHIFT;
  localparam int unsigned DD_SHIFT   = 2;
  localparam int unsigned DD_W       = 6;

  // Arithmetic widths
  localparam int unsigned DVD_W   = 32;
  localparam int unsigned DVS_W   = 16;
  localparam int unsigned MUL_A_W = 18;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned PART_W  = 17;
  localparam int unsigned LVL_W   = 18;
  localparam int unsigned ACC_W   = 16;
  localparam int unsigned PROBE_W = 8;

  // Pulse-density constants
  localparam logic [ACC_W-1:0] ACC_RELOAD = 16'h0100;
  localparam logic [ACC_W-1:0] ACC_BIAS   = 16'd4;
  localparam int unsigned      CUBE_SHIFT = 9;

  // Register reset values
  localparam logic [THR_W-1:0] RST_ON_THR     = 8'd71;
  localparam logic [THR_W-1:0] RST_OFF_THR    = 8'd6;
  localparam logic [THR_W-1:0] RST_DIST_LIMIT = 8'd21;
  localparam logic [THR_W-1:0] RST_PROBE_INT  = 8'd60;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_TICK    = 2'd1,
    OP_STATUS  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_ON    = 2'd1,
    CMD_OFF   = 2'd2,
    CMD_PROBE = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISABLE    = 3'd0,
    REG_ON_THR     = 3'd1,
    REG_OFF_THR    = 3'd2,
    REG_DIST_LIMIT = 3'd3,
    REG_PROBE_INT  = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    MUL_REQ  = 3'd0,
    MUL_PART = 3'd1,
    MUL_CUR  = 3'd2,
    MUL_SQ   = 3'd3,
    MUL_CUBE = 3'd4
  } mul_sel_e;

  typedef enum logic [1:0] {
    DIV_MINE = 2'd0,
    DIV_PART = 2'd1,
    DIV_ST   = 2'd2,
    DIV_EN   = 2'd3
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL_REQ,
    ST_DIV_MINE,
    ST_MUL_PART,
    ST_DIV_PART,
    ST_MUL_CUR,
    ST_CHECK,
    ST_DIV_ST,
    ST_DIV_EN,
    ST_LEVEL,
    ST_MUL_SQ,
    ST_MUL_CUBE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic     load;
    logic     mul_go;
    mul_sel_e mul_sel;
    logic     div_go;
    div_sel_e div_sel;
    logic     finish;
  } repd_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       port_ok;
    logic       pak_ok;
    logic       req_ok;
    logic       env_active;
    logic       mine_lt_cur;
    logic       need_cube;
    logic       div_busy;
    logic       div_done;
    logic       out_free;
  } repd_stat_t;

endpackage

### rtl/repd_div.sv
// Radix-2 restoring divider for unsigned magnitudes, one quotient bit a cycle.
module repd_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [repd_pkg::DVD_W-1:0] dividend_i,
  input  logic [repd_pkg::DVS_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [repd_pkg::DVD_W-1:0] quotient_o
);
  import repd_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DVS_W:0]   rem_sh, rem_sub;
  logic             fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_q, quo_q[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = (rem_sh >= {1'b0, dvs_q});
  end

  // Control: run for DVD_W steps, then pulse done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Operands and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], fits};
      rem_q <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### rtl/repd_dp.sv
// Datapath: item and port state, shared multiplier, divider and result register.
module repd_dp #(
  parameter int unsigned NUM_PORTS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  repd_pkg::repd_cmd_t             cmd_i,
  output repd_pkg::repd_stat_t            stat_o,
  input  logic                            s_valid_i,
  input  logic [repd_pkg::IN_DATA_W-1:0]  s_data_i,
  input  logic [repd_pkg::IN_USER_W-1:0]  s_user_i,
  input  logic                            m_ready_i,
  output logic                            m_valid_o,
  output logic [repd_pkg::OUT_DATA_W-1:0] m_data_o,
  input  logic                            cfg_we_i,
  input  logic [repd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [repd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import repd_pkg::*;

  localparam int unsigned PORT_IW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  // Configuration registers
  logic             dis_q;
  logic [THR_W-1:0] on_thr_q, off_thr_q, dist_lim_q, probe_int_q;

  // Request under work
  logic [1:0]         op_q;
  logic [PORT_W-1:0]  ctrl_q;
  logic [DUR_W-1:0]   dur_q;
  logic [LEVEL_W-1:0] st_q, en_q;
  logic [DIST_W-1:0]  dist_q;
  logic               pak_in_q;

  // Per-port state
  logic               pak_q     [NUM_PORTS];
  logic               motor_q   [NUM_PORTS];
  logic [LEVEL_W-1:0] start_q   [NUM_PORTS];
  logic [LEVEL_W-1:0] end_q     [NUM_PORTS];
  logic [DUR_W-1:0]   len_q     [NUM_PORTS];
  logic [DUR_W-1:0]   env_rem_q [NUM_PORTS];
  logic [ACC_W-1:0]   acc_q     [NUM_PORTS];
  logic [PROBE_W-1:0] probe_q;

  // Work registers
  logic [PROD_W-1:0]  prod_q;
  logic               neg_q;
  div_sel_e           div_sel_q;
  logic [LEVEL_W-1:0] mine_q, nst_q, nen_q;
  logic [PART_W-1:0]  part_q;
  logic               m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  // Selected port view
  logic [PORT_IW-1:0] p;
  logic               port_ok;
  logic               pak_cur, motor_cur;
  logic [LEVEL_W-1:0] st_cur, en_cur;
  logic [DUR_W-1:0]   len_cur, rem_cur;
  logic [ACC_W-1:0]   acc_cur;

  logic [DSC_W-1:0]   d_sc;
  logic [DD_W-1:0]    dd;
  logic               req_ok, env_active, mine_lt_cur, need_cube, req_acc;
  logic [LVL_W-1:0]   lvl;
  logic               ge_on, lt_off, acc_low;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_w;
  logic [PART_W-1:0]  half;

  logic [DVD_W-1:0]   dvd_s, dvd_mag, quo, quo_s;
  logic [DVS_W-1:0]   dvs;
  logic               div_busy, div_done;

  logic [DUR_W-1:0]   rem_dec;
  logic [PROBE_W:0]   probe_n;
  logic               probe_fire;
  cmd_e               t_cmd, res_cmd;
  logic               t_motor, res_acc;
  logic [ACC_W-1:0]   t_acc, cube_add;
  logic [PORT_W-1:0]  res_port;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dis_q       <= 1'b0;
      on_thr_q    <= RST_ON_THR;
      off_thr_q   <= RST_OFF_THR;
      dist_lim_q  <= RST_DIST_LIMIT;
      probe_int_q <= RST_PROBE_INT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DISABLE:    dis_q       <= cfg_data_i[0];
        REG_ON_THR:     on_thr_q    <= cfg_data_i;
        REG_OFF_THR:    off_thr_q   <= cfg_data_i;
        REG_DIST_LIMIT: dist_lim_q  <= cfg_data_i;
        REG_PROBE_INT:  probe_int_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && s_valid_i) begin
      op_q     <= s_user_i;
      ctrl_q   <= s_data_i[CTRL_LSB +: PORT_W];
      dur_q    <= s_data_i[DUR_LSB +: DUR_W];
      st_q     <= s_data_i[START_LSB +: LEVEL_W];
      en_q     <= s_data_i[END_LSB +: LEVEL_W];
      dist_q   <= s_data_i[DIST_LSB +: DIST_W];
      pak_in_q <= s_data_i[PAK_BIT];
    end
  end

  // Port view and decisions
  always_comb begin
    p         = PORT_IW'(ctrl_q);
    port_ok   = (32'(ctrl_q) < NUM_PORTS);
    pak_cur   = pak_q[p];
    motor_cur = motor_q[p];
    st_cur    = start_q[p];
    en_cur    = end_q[p];
    len_cur   = len_q[p];
    rem_cur   = env_rem_q[p];
    acc_cur   = acc_q[p];

    d_sc = dist_q[DIST_LSB - DIST_LSB + DIST_SHIFT +: DSC_W];
    dd   = (d_sc[DD_SHIFT +: DD_W] == '0) ? DD_W'(1) : d_sc[DD_SHIFT +: DD_W];

    req_ok      = pak_cur && (d_sc < DSC_W'(dist_lim_q)) && !dis_q;
    env_active  = (len_cur != '0);
    mine_lt_cur = ($signed(mine_q) < $signed(prod_q[LEVEL_W-1:0]));
    req_acc     = req_ok && (!env_active || !mine_lt_cur);

    lvl = env_active ? ({part_q[PART_W-1], part_q} + {{2{st_cur[LEVEL_W-1]}}, st_cur})
                     : '0;
    ge_on     = ($signed(lvl) >= $signed({{(LVL_W-THR_W){1'b0}}, on_thr_q}));
    lt_off    = ($signed(lvl) <  $signed({{(LVL_W-THR_W){1'b0}}, off_thr_q}));
    acc_low   = (acc_cur < ACC_RELOAD);
    need_cube = !ge_on && !lt_off && acc_low;
  end

  // Shared multiplier operands
  always_comb begin
    half  = {part_q[PART_W-1], part_q[PART_W-1:1]};
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_REQ: begin
        mul_a = {{2{st_q[LEVEL_W-1]}}, st_q} + {{2{en_q[LEVEL_W-1]}}, en_q};
        mul_b = {2'b00, dur_q};
      end
      MUL_PART: begin
        mul_a = {{2{en_cur[LEVEL_W-1]}}, en_cur} - {{2{st_cur[LEVEL_W-1]}}, st_cur};
        mul_b = {2'b00, len_cur - rem_cur};
      end
      MUL_CUR: begin
        mul_a = {half[PART_W-1], half} + {{2{st_cur[LEVEL_W-1]}}, st_cur};
        mul_b = {2'b00, rem_cur};
      end
      MUL_SQ: begin
        mul_a = {{(MUL_A_W-THR_W){1'b0}}, lvl[THR_W-1:0]};
        mul_b = {{(MUL_B_W-THR_W){1'b0}}, lvl[THR_W-1:0]};
      end
      MUL_CUBE: begin
        mul_a = {2'b00, prod_q[ACC_W-1:0]};
        mul_b = {{(MUL_B_W-THR_W){1'b0}}, lvl[THR_W-1:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_w = {{MUL_B_W{mul_a[MUL_A_W-1]}}, mul_a} * {{MUL_A_W{mul_b[MUL_B_W-1]}}, mul_b};
  end

  // Register each product
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) begin
      prod_q <= prod_w;
    end
  end

  // Divider operands: magnitude in, sign applied on the way out
  always_comb begin
    dvd_s = '0;
    dvs   = '0;
    case (cmd_i.div_sel)
      DIV_MINE: begin
        dvd_s = prod_q[DVD_W-1:0];
        dvs   = {{(DVS_W-DD_W-1){1'b0}}, dd, 1'b0};
      end
      DIV_PART: begin
        dvd_s = prod_q[DVD_W-1:0];
        dvs   = {1'b0, len_cur};
      end
      DIV_ST: begin
        dvd_s = {{(DVD_W-LEVEL_W){st_q[LEVEL_W-1]}}, st_q};
        dvs   = {{(DVS_W-DD_W){1'b0}}, dd};
      end
      DIV_EN: begin
        dvd_s = {{(DVD_W-LEVEL_W){en_q[LEVEL_W-1]}}, en_q};
        dvs   = {{(DVS_W-DD_W){1'b0}}, dd};
      end
      default: begin
        dvd_s = '0;
        dvs   = '0;
      end
    endcase
    dvd_mag = dvd_s[DVD_W-1] ? (~dvd_s + 1'b1) : dvd_s;
    quo_s   = neg_q ? (~quo + 1'b1) : quo;
  end

  repd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (dvd_mag),
    .divisor_i  (dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Hold sign and target, then file the quotient
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_go) begin
      neg_q     <= dvd_s[DVD_W-1];
      div_sel_q <= cmd_i.div_sel;
    end
    if (div_done) begin
      case (div_sel_q)
        DIV_MINE: mine_q <= quo_s[LEVEL_W-1:0];
        DIV_PART: part_q <= quo_s[PART_W-1:0];
        DIV_ST:   nst_q  <= quo_s[LEVEL_W-1:0];
        DIV_EN:   nen_q  <= quo_s[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Tick outcome and result fields
  always_comb begin
    rem_dec    = rem_cur - 1'b1;
    probe_n    = {1'b0, probe_q} + 1'b1;
    probe_fire = (probe_n > {1'b0, probe_int_q});
    cube_add   = prod_q[CUBE_SHIFT +: ACC_W];

    t_cmd   = CMD_NONE;
    t_motor = motor_cur;
    t_acc   = acc_cur;
    if (ge_on) begin
      if (!motor_cur) begin
        t_motor = 1'b1;
        t_cmd   = CMD_ON;
      end
    end else if (lt_off) begin
      if (motor_cur) begin
        t_motor = 1'b0;
        t_cmd   = CMD_OFF;
      end
    end else if (!acc_low) begin
      t_acc = acc_cur - ACC_RELOAD;
      if (!motor_cur) begin
        t_motor = 1'b1;
        t_cmd   = CMD_ON;
      end
    end else begin
      t_acc = acc_cur + cube_add + ACC_BIAS;
      if (motor_cur) begin
        t_motor = 1'b0;
        t_cmd   = CMD_OFF;
      end
    end

    res_cmd  = CMD_NONE;
    res_port = ctrl_q;
    res_acc  = 1'b0;
    if (port_ok) begin
      case (op_q)
        OP_REQUEST: res_acc = req_acc;
        OP_TICK: begin
          if (!pak_cur) begin
            if (probe_fire) begin
              res_cmd  = CMD_PROBE;
              res_port = '0;
            end
          end else begin
            res_cmd = t_cmd;
          end
        end
        default: ;
      endcase
    end
  end

  // Commit port state at the end of the item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        pak_q[i]     <= 1'b0;
        motor_q[i]   <= 1'b0;
        start_q[i]   <= '0;
        end_q[i]     <= '0;
        len_q[i]     <= '0;
        env_rem_q[i] <= '0;
        acc_q[i]     <= '0;
      end
      probe_q <= '0;
    end else if (cmd_i.finish && port_ok) begin
      case (op_q)
        OP_REQUEST: begin
          if (req_acc) begin
            motor_q[p]   <= 1'b0;
            start_q[p]   <= nst_q;
            end_q[p]     <= nen_q;
            len_q[p]     <= dur_q;
            env_rem_q[p] <= dur_q;
            acc_q[p]     <= ACC_RELOAD;
          end
        end
        OP_TICK: begin
          if (!pak_cur) begin
            probe_q <= probe_fire ? '0 : probe_n[PROBE_W-1:0];
          end else begin
            if (env_active) begin
              env_rem_q[p] <= rem_dec;
              if (rem_dec == '0) begin
                len_q[p] <= '0;
              end
            end
            motor_q[p] <= t_motor;
            acc_q[p]   <= t_acc;
          end
        end
        OP_STATUS: pak_q[p] <= pak_in_q;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      m_data_q <= {3'b000, res_acc, res_port, res_cmd};
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

  // Status for the controller
  always_comb begin
    stat_o.op          = op_q;
    stat_o.port_ok     = port_ok;
    stat_o.pak_ok      = pak_cur;
    stat_o.req_ok      = req_ok;
    stat_o.env_active  = env_active;
    stat_o.mine_lt_cur = mine_lt_cur;
    stat_o.need_cube   = need_cube;
    stat_o.div_busy    = div_busy;
    stat_o.div_done    = div_done;
    stat_o.out_free    = !m_valid_q || m_ready_i;
  end

endmodule

### rtl/repd_ctrl.sv
// Controller: sequences multiply and divide steps for one request at a time.
module repd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  input  repd_pkg::repd_stat_t  stat_i,
  output repd_pkg::repd_cmd_t   cmd_o
);
  import repd_pkg::*;

  state_e state_q, state_d;
  logic   div_idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o.load    = 1'b0;
    cmd_o.mul_go  = 1'b0;
    cmd_o.mul_sel = MUL_REQ;
    cmd_o.div_go  = 1'b0;
    cmd_o.div_sel = DIV_MINE;
    cmd_o.finish  = 1'b0;
    div_idle      = !stat_i.div_busy && !stat_i.div_done;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = 1'b1;
        if (s_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_FINISH;
        if (stat_i.port_ok) begin
          if (stat_i.op == OP_REQUEST) begin
            if (stat_i.req_ok) begin
              state_d = stat_i.env_active ? ST_MUL_REQ : ST_DIV_ST;
            end
          end else if (stat_i.op == OP_TICK) begin
            if (stat_i.pak_ok) begin
              state_d = stat_i.env_active ? ST_MUL_PART : ST_LEVEL;
            end
          end
        end
      end
      ST_MUL_REQ: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = MUL_REQ;
        state_d       = ST_DIV_MINE;
      end
      ST_DIV_MINE: begin
        cmd_o.div_sel = DIV_MINE;
        cmd_o.div_go  = div_idle;
        if (stat_i.div_done) begin
          state_d = ST_MUL_PART;
        end
      end
      ST_MUL_PART: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = MUL_PART;
        state_d       = ST_DIV_PART;
      end
      ST_DIV_PART: begin
        cmd_o.div_sel = DIV_PART;
        cmd_o.div_go  = div_idle;
        if (stat_i.div_done) begin
          state_d = (stat_i.op == OP_REQUEST) ? ST_MUL_CUR : ST_LEVEL;
        end
      end
      ST_MUL_CUR: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = MUL_CUR;
        state_d       = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = stat_i.mine_lt_cur ? ST_FINISH : ST_DIV_ST;
      end
      ST_DIV_ST: begin
        cmd_o.div_sel = DIV_ST;
        cmd_o.div_go  = div_idle;
        if (stat_i.div_done) begin
          state_d = ST_DIV_EN;
        end
      end
      ST_DIV_EN: begin
        cmd_o.div_sel = DIV_EN;
        cmd_o.div_go  = div_idle;
        if (stat_i.div_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_LEVEL: begin
        state_d = stat_i.need_cube ? ST_MUL_SQ : ST_FINISH;
      end
      ST_MUL_SQ: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = MUL_SQ;
        state_d       = ST_MUL_CUBE;
      end
      ST_MUL_CUBE: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = MUL_CUBE;
        state_d       = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### rtl/rumble_envelope_pwm_driver.sv
// A status report, an unknown operation or a request rejected before the strength check goes
// straight to the result; a tick adds the partial-level division while an envelope runs and the
// pulse-density cube if needed; a request on an idle port divides its start and end levels, one
// on a running envelope checks its strength and divides only if it replaces. Divisions use the
// radix-2 divider. One request is in flight, the next taken once its result is registered; a full
// output register holds the controller. Reset: async, active low, clears control, config, ports.
module rumble_envelope_pwm_driver #(
  parameter int unsigned NUM_PORTS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // controller, duration, start_level, end_level, distance, pak_present, zero fill
  input  logic [repd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic [repd_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // command, command_port, accepted, zero fill
  output logic [repd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [repd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [repd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import repd_pkg::*;

  repd_cmd_t  cmd;
  repd_stat_t stat;

  repd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  repd_dp #(
    .NUM_PORTS (NUM_PORTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .s_valid_i   (s_axis_tvalid),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_data_o    (m_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  assign s_axis_tready = cmd.load;

`ifndef SYNTHESIS
  // Only one request is in work at a time
  a_single_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while one is in work");

  // A fresh result goes out as the controller returns to idle
  a_result_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result registered without the controller going idle");

  // The divider only runs while a request is in work
  a_div_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.div_busy |-> !s_axis_tready)
    else $error("divider busy while accepting requests");
`endif

endmodule
